>>> rtl/sirf_pkg.sv
// ----------------------------------------------------------------------------
// Signed integer radix formatter package
// Widths, register indexes and symbol codes shared by the formatter and its
// checker.
// ----------------------------------------------------------------------------
package sirf_pkg;

   localparam int unsigned MAX_SYMBOLS_DEFAULT = 16;
   localparam int unsigned MIN_SYMBOLS         = 2;

   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned COUNT_W     = 5;
   localparam int unsigned WORD_W      = 64;
   localparam int unsigned ALPHA_W     = 2 * WORD_W;
   localparam int unsigned DIGIT_W     = 4;
   localparam int unsigned NIBBLES     = VALUE_W / DIGIT_W;
   localparam int unsigned NIB_W       = $clog2(NIBBLES);
   localparam int unsigned MAX_DIGITS  = VALUE_W;
   localparam int unsigned DCNT_W      = $clog2(MAX_DIGITS + 1);
   localparam int unsigned CSR_INDEX_W = 2;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SYMBOL_COUNT = 2'd0,
      CSR_SYMBOLS_LOW  = 2'd1,
      CSR_SYMBOLS_HIGH = 2'd2
   } csr_index_type;

   localparam logic [BYTE_W-1:0] SYM_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] SYM_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] SYM_NUL   = 8'h00;

endpackage

>>> rtl/signed_integer_radix_formatter.sv
// ----------------------------------------------------------------------------
// Signed integer radix formatter
// Writes a signed 32-bit value as text in a radix of 2 to 16 symbols, most
// significant digit first, one byte per cycle on the response port.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken when start is high and busy is low. Each response byte
//   is shown for one cycle with rsp_strobe high; rsp_last marks the final
//   byte. The receiver cannot stall, so bytes are never held back.
//   The csr channel writes symbol_count, symbols_low and symbols_high; it is
//   always ready and must only be used while busy is low.
// Operation:
//   First the alphabet check, one symbol against all later ones a cycle;
//   then the division: a 4-bit-per-cycle divider walks the 32-bit
//   magnitude one nibble a cycle, and each whole pass gives one digit.
//   Then an optional '-' byte and one byte for each digit. Every byte leaves
//   through an output register in the cycle after the state that makes it,
//   and busy falls in the cycle that shows the final byte.
//   An out-of-range symbol count skips all of this and shows a single zero
//   byte through the fail state and the output register; a failed check
//   shows it the same way after the last check.
// Reset (synchronous, active high) returns the block to idle and clears the
//   configuration registers to zero.
// ----------------------------------------------------------------------------
module signed_integer_radix_formatter #(
   parameter int unsigned MAX_SYMBOLS = sirf_pkg::MAX_SYMBOLS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic signed [sirf_pkg::VALUE_W-1:0]  req_value,
   output logic                                 rsp_strobe,
   output logic        [sirf_pkg::BYTE_W-1:0]   rsp_text_byte,
   output logic                                 rsp_last,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [sirf_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [sirf_pkg::WORD_W-1:0]          csr_data
);

   localparam int unsigned CountW  = sirf_pkg::COUNT_W;
   localparam int unsigned ValueW  = sirf_pkg::VALUE_W;
   localparam int unsigned ByteW   = sirf_pkg::BYTE_W;
   localparam int unsigned DigitW  = sirf_pkg::DIGIT_W;
   localparam int unsigned NibW    = sirf_pkg::NIB_W;
   localparam int unsigned DcntW   = sirf_pkg::DCNT_W;
   localparam int unsigned Digits  = sirf_pkg::MAX_DIGITS;
   localparam int unsigned ChkW    = MAX_SYMBOLS * ByteW;
   localparam int unsigned DivW    = CountW + DigitW;
   localparam logic [NibW-1:0] NibLast = NibW'(sirf_pkg::NIBBLES - 1);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_DIVIDE = 6'b000100,
      ST_SIGN   = 6'b001000,
      ST_DIGITS = 6'b010000,
      ST_FAIL   = 6'b100000
   } state_type;

   state_type                                state_ff, state_in;
   logic [CountW-1:0]                        count_ff, count_in;
   logic [sirf_pkg::WORD_W-1:0]              sym_low_ff, sym_low_in;
   logic [sirf_pkg::WORD_W-1:0]              sym_high_ff, sym_high_in;
   logic                                     neg_ff, neg_in;
   logic [ValueW-1:0]                        mag_ff, mag_in;
   logic [DigitW-1:0]                        rem_ff, rem_in;
   logic [NibW-1:0]                          nib_ff, nib_in;
   logic [Digits-1:0][DigitW-1:0]            stack_ff, stack_in;
   logic [DcntW-1:0]                         dcnt_ff, dcnt_in;
   logic [ChkW-1:0]                          chk_sym_ff, chk_sym_in;
   logic [MAX_SYMBOLS-1:0]                   chk_mask_ff, chk_mask_in;
   logic                                     bad_ff, bad_in;
   logic                                     rsp_strobe_ff, rsp_strobe_in;
   logic [ByteW-1:0]                         rsp_text_byte_ff, rsp_text_byte_in;
   logic                                     rsp_last_ff, rsp_last_in;

   logic [sirf_pkg::ALPHA_W-1:0]             alphabet;
   logic [ValueW-1:0]                        raw;
   logic [ValueW-1:0]                        mag_load;
   logic [MAX_SYMBOLS-1:0]                   mask_load;
   logic                                     count_bad;
   logic [DivW-1:0]                          div_cur;
   logic [DivW-1:0]                          div_step;
   logic [DigitW-1:0]                        div_q;
   logic [DigitW-1:0]                        div_rem;
   logic [ValueW-1:0]                        mag_shift;
   logic [ByteW-1:0]                         chk_head;
   logic                                     chk_hit;
   logic                                     bad_now;

   assign alphabet  = {sym_high_ff, sym_low_ff};
   assign raw       = req_value;
   assign mag_load  = raw[ValueW-1] ? (~raw + ValueW'(1)) : raw;
   assign count_bad = (count_ff < CountW'(sirf_pkg::MIN_SYMBOLS)) ||
                      (count_ff > CountW'(MAX_SYMBOLS));

   always_comb begin
      for (int j = 0; j < MAX_SYMBOLS; j++) begin
         mask_load[j] = (CountW'(j) < count_ff);
      end
   end

   // Restoring division of the remainder and the next nibble by the radix.
   always_comb begin
      div_cur  = {1'b0, rem_ff, mag_ff[ValueW-1 -: DigitW]};
      div_step = '0;
      div_q    = '0;
      for (int b = DigitW - 1; b >= 0; b--) begin
         div_step = DivW'({{DigitW{1'b0}}, count_ff}) << b;
         if (div_cur >= div_step) begin
            div_cur  = div_cur - div_step;
            div_q[b] = 1'b1;
         end
      end
   end

   assign div_rem   = div_cur[DigitW-1:0];
   assign mag_shift = {mag_ff[ValueW-DigitW-1:0], div_q};

   // The symbol at the bottom of the check register is compared against
   // every symbol still above it, so each pair is seen exactly once.
   assign chk_head = chk_sym_ff[ByteW-1:0];

   always_comb begin
      chk_hit = 1'b0;
      for (int k = 1; k < MAX_SYMBOLS; k++) begin
         if (chk_mask_ff[k] && (chk_sym_ff[k*ByteW +: ByteW] == chk_head)) begin
            chk_hit = 1'b1;
         end
      end
   end

   assign bad_now = chk_mask_ff[0] &&
                    ((chk_head == sirf_pkg::SYM_PLUS) ||
                     (chk_head == sirf_pkg::SYM_MINUS) || chk_hit);

   always_comb begin
      count_in    = count_ff;
      sym_low_in  = sym_low_ff;
      sym_high_in = sym_high_ff;
      if (csr_valid) begin
         case (sirf_pkg::csr_index_type'(csr_index))
            sirf_pkg::CSR_SYMBOL_COUNT: count_in    = csr_data[CountW-1:0];
            sirf_pkg::CSR_SYMBOLS_LOW:  sym_low_in  = csr_data;
            sirf_pkg::CSR_SYMBOLS_HIGH: sym_high_in = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in         = state_ff;
      neg_in           = neg_ff;
      mag_in           = mag_ff;
      rem_in           = rem_ff;
      nib_in           = nib_ff;
      stack_in         = stack_ff;
      dcnt_in          = dcnt_ff;
      chk_sym_in       = chk_sym_ff;
      chk_mask_in      = chk_mask_ff;
      bad_in           = bad_ff;
      rsp_strobe_in    = 1'b0;
      rsp_text_byte_in = rsp_text_byte_ff;
      rsp_last_in      = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               neg_in      = raw[ValueW-1];
               mag_in      = mag_load;
               rem_in      = '0;
               nib_in      = '0;
               dcnt_in     = '0;
               chk_sym_in  = alphabet[ChkW-1:0];
               chk_mask_in = mask_load;
               bad_in      = 1'b0;
               state_in    = count_bad ? ST_FAIL : ST_CHECK;
            end
         end
         ST_CHECK: begin
            chk_sym_in  = chk_sym_ff >> ByteW;
            chk_mask_in = chk_mask_ff >> 1;
            bad_in      = bad_ff | bad_now;
            if (!chk_mask_ff[1]) begin
               state_in = (bad_ff | bad_now) ? ST_FAIL : ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            mag_in = mag_shift;
            rem_in = div_rem;
            nib_in = (nib_ff == NibLast) ? '0 : nib_ff + NibW'(1);
            if (nib_ff == NibLast) begin
               // A whole pass is done: the remainder is the next digit up.
               rem_in   = '0;
               stack_in = {stack_ff[Digits-2:0], div_rem};
               dcnt_in  = dcnt_ff + DcntW'(1);
               if (mag_shift == '0) begin
                  state_in = neg_ff ? ST_SIGN : ST_DIGITS;
               end
            end
         end
         ST_SIGN: begin
            rsp_strobe_in    = 1'b1;
            rsp_text_byte_in = sirf_pkg::SYM_MINUS;
            state_in         = ST_DIGITS;
         end
         ST_DIGITS: begin
            rsp_strobe_in    = 1'b1;
            rsp_text_byte_in = alphabet[{stack_ff[0], 3'b000} +: ByteW];
            rsp_last_in      = (dcnt_ff == DcntW'(1));
            stack_in         = {{DigitW{1'b0}}, stack_ff[Digits-1:1]};
            dcnt_in          = dcnt_ff - DcntW'(1);
            if (dcnt_ff == DcntW'(1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_FAIL: begin
            rsp_strobe_in    = 1'b1;
            rsp_text_byte_in = sirf_pkg::SYM_NUL;
            rsp_last_in      = 1'b1;
            state_in         = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         sym_low_ff    <= '0;
         sym_high_ff   <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         sym_low_ff    <= sym_low_in;
         sym_high_ff   <= sym_high_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff           <= neg_in;
      mag_ff           <= mag_in;
      rem_ff           <= rem_in;
      nib_ff           <= nib_in;
      stack_ff         <= stack_in;
      dcnt_ff          <= dcnt_in;
      chk_sym_ff       <= chk_sym_in;
      chk_mask_ff      <= chk_mask_in;
      bad_ff           <= bad_in;
      rsp_text_byte_ff <= rsp_text_byte_in;
      rsp_last_ff      <= rsp_last_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign csr_ready     = 1'b1;
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_text_byte = rsp_text_byte_ff;
   assign rsp_last      = rsp_last_ff;

endmodule

>>> rtl/sirf_checker.sv
// ----------------------------------------------------------------------------
// Signed integer radix formatter checker
// Port-level assertions on request and response sequencing, bound to the
// top level.
// ----------------------------------------------------------------------------
module sirf_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_strobe,
   input logic [sirf_pkg::BYTE_W-1:0]   rsp_text_byte,
   input logic                          rsp_last
);

   // A taken request always keeps the block busy on the next cycle.
   assert property (@(posedge clock) disable iff (reset) start && !busy |=> busy)
      else $error("request taken but block not busy afterwards");

   // Bytes only appear while a request is in progress.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> $past(busy))
      else $error("response byte without a request in progress");

   // The final byte frees the block in the same cycle.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe && rsp_last |-> !busy)
      else $error("block still busy after the final byte");

   // The bytes of one request come without gaps.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |=> rsp_strobe)
      else $error("gap in the bytes of one request");

   // A minus sign can only lead the text, never end it.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_text_byte == sirf_pkg::SYM_MINUS) |-> !rsp_last)
      else $error("minus sign sent as the final byte");

endmodule

bind signed_integer_radix_formatter sirf_checker u_sirf_checker (.*);

>>> test/signed_integer_radix_formatter_test.sv
// ----------------------------------------------------------------------------
// Signed integer radix formatter testbench
// Sends signed values through the request port and rewrites the alphabet
// between batches, including invalid and extreme settings. A scoreboard
// works out the text bytes that each accepted request should produce and
// checks every strobed response byte against them in order.
// ----------------------------------------------------------------------------
module signed_integer_radix_formatter_test;

   localparam int unsigned VALUE_W     = sirf_pkg::VALUE_W;
   localparam int unsigned BYTE_W      = sirf_pkg::BYTE_W;
   localparam int unsigned COUNT_W     = sirf_pkg::COUNT_W;
   localparam int unsigned WORD_W      = sirf_pkg::WORD_W;
   localparam int unsigned ALPHA_W     = sirf_pkg::ALPHA_W;
   localparam int unsigned DIGIT_W     = sirf_pkg::DIGIT_W;
   localparam int unsigned MAX_DIGITS  = sirf_pkg::MAX_DIGITS;
   localparam int unsigned CSR_INDEX_W = sirf_pkg::CSR_INDEX_W;

   localparam int unsigned IDLE_LIMIT   = 3000;
   localparam int unsigned DRAIN_CYCLES = 40;
   localparam int unsigned TARGET_ITEMS = 110;
   localparam int unsigned CALM_FROM    = 90;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;

   // "0123456789ABCDEF", digit 0 in the lowest byte.
   localparam logic [ALPHA_W-1:0] HEX_ALPHABET =
      {64'h4645444342413938, 64'h3736353433323130};

   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

   typedef enum int {
      FLAW_SHORT,
      FLAW_LONG,
      FLAW_PLUS,
      FLAW_MINUS,
      FLAW_REPEAT
   } alphabet_flaw_type;

   typedef struct {
      logic [BYTE_W-1:0] text_byte;
      logic              last;
   } text_entry_type;

   class radix_text_checker;
      logic [COUNT_W-1:0] radix;
      logic [WORD_W-1:0]  sym_low;
      logic [WORD_W-1:0]  sym_high;
      text_entry_type     expected_text[$];
      int unsigned        errors;

      function new();
         radix    = '0;
         sym_low  = '0;
         sym_high = '0;
         errors   = 0;
      endfunction

      task report(input string what);
         errors++;
         $display("mismatch: %s", what);
      endtask

      function void note_config(input logic [CSR_INDEX_W-1:0] index,
                                input logic [WORD_W-1:0] data);
         case (index)
            sirf_pkg::CSR_SYMBOL_COUNT: radix = data[COUNT_W-1:0];
            sirf_pkg::CSR_SYMBOLS_LOW:  sym_low = data;
            sirf_pkg::CSR_SYMBOLS_HIGH: sym_high = data;
            default: ;
         endcase
      endfunction

      function logic [BYTE_W-1:0] symbol(input int unsigned d);
         if (d < 8)
            return sym_low[BYTE_W*d +: BYTE_W];
         return sym_high[BYTE_W*(d-8) +: BYTE_W];
      endfunction

      function bit alphabet_valid();
         logic [BYTE_W-1:0] s;
         if (radix < sirf_pkg::MIN_SYMBOLS || radix > sirf_pkg::MAX_SYMBOLS_DEFAULT)
            return 1'b0;
         for (int unsigned i = 0; i < radix; i++) begin
            s = symbol(i);
            if (s == sirf_pkg::SYM_PLUS || s == sirf_pkg::SYM_MINUS)
               return 1'b0;
            for (int unsigned j = i + 1; j < radix; j++)
               if (symbol(j) == s)
                  return 1'b0;
         end
         return 1'b1;
      endfunction

      function void push_text(input logic [BYTE_W-1:0] b, input logic l);
         text_entry_type entry;
         entry.text_byte = b;
         entry.last      = l;
         expected_text.push_back(entry);
      endfunction

      function void note_value(input logic signed [VALUE_W-1:0] value);
         logic [VALUE_W-1:0] mag;
         logic [DIGIT_W-1:0] digits [MAX_DIGITS];
         int                 nd;
         if (!alphabet_valid()) begin
            push_text(sirf_pkg::SYM_NUL, 1'b1);
            return;
         end
         // The magnitude is taken unsigned, so the most negative value is safe.
         mag = value;
         if (value[VALUE_W-1])
            mag = -mag;
         nd = 0;
         do begin
            digits[nd] = DIGIT_W'(mag % radix);
            mag = mag / radix;
            nd++;
         end while (mag != 0);
         if (value[VALUE_W-1])
            push_text(sirf_pkg::SYM_MINUS, 1'b0);
         for (int k = nd - 1; k >= 0; k--)
            push_text(symbol(digits[k]), k == 0);
      endfunction

      task check_byte(input logic [BYTE_W-1:0] b, input logic l);
         text_entry_type want;
         if (expected_text.size() == 0) begin
            report($sformatf("byte %02h last %0b with no request waiting", b, l));
            return;
         end
         want = expected_text.pop_front();
         if (b !== want.text_byte)
            report($sformatf("text byte %02h, wanted %02h", b, want.text_byte));
         if (l !== want.last)
            report($sformatf("last %0b, wanted %0b", l, want.last));
      endtask

      function int unsigned outstanding();
         return expected_text.size();
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        start;
   logic                        busy;
   logic signed [VALUE_W-1:0]   req_value;
   logic                        rsp_strobe;
   logic        [BYTE_W-1:0]    rsp_text_byte;
   logic                        rsp_last;
   logic                        csr_valid;
   logic                        csr_ready;
   logic [CSR_INDEX_W-1:0]      csr_index;
   logic [WORD_W-1:0]           csr_data;

   radix_text_checker text_check;
   int unsigned       idle_cycles;
   bit                progress;
   int unsigned       sent;

   signed_integer_radix_formatter u_top (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_text_byte (rsp_text_byte),
      .rsp_last      (rsp_last),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Every handshake is booked here, in one place, at the rising edge.
   always @(posedge clock) begin
      if (!reset) begin
         progress = 1'b0;
         if (csr_valid && csr_ready) begin
            text_check.note_config(csr_index, csr_data);
            progress = 1'b1;
         end
         if (start && !busy) begin
            text_check.note_value(req_value);
            progress = 1'b1;
         end
         if (rsp_strobe) begin
            text_check.check_byte(rsp_text_byte, rsp_last);
            progress = 1'b1;
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   task send_value(input logic signed [VALUE_W-1:0] value, input int unsigned gap);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start     <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (busy);
      @(negedge clock);
      sent++;
   endtask

   // Drops start and waits until every byte of every request has come out.
   task settle();
      start <= 1'b0;
      @(negedge clock);
      while (busy || text_check.outstanding() != 0)
         @(negedge clock);
   endtask

   // Leaves csr_valid high; the caller lowers it after its last write.
   task write_reg(input logic [CSR_INDEX_W-1:0] index, input logic [WORD_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task load_alphabet(input logic [COUNT_W-1:0] count, input logic [ALPHA_W-1:0] alpha);
      logic [WORD_W-1:0] count_word;
      settle();
      // The bits above the count field are noise that the block must drop.
      count_word = {$urandom, $urandom};
      count_word[COUNT_W-1:0] = count;
      write_reg(sirf_pkg::CSR_SYMBOL_COUNT, count_word);
      write_reg(sirf_pkg::CSR_SYMBOLS_LOW, alpha[WORD_W-1:0]);
      write_reg(sirf_pkg::CSR_SYMBOLS_HIGH, alpha[ALPHA_W-1:WORD_W]);
      csr_valid <= 1'b0;
   endtask

   task write_spare();
      settle();
      write_reg(CSR_SPARE, {$urandom, $urandom});
      csr_valid <= 1'b0;
   endtask

   function automatic logic [ALPHA_W-1:0] put_symbol(input logic [ALPHA_W-1:0] alpha,
                                                     input int unsigned pos,
                                                     input logic [BYTE_W-1:0] b);
      alpha[BYTE_W*pos +: BYTE_W] = b;
      return alpha;
   endfunction

   function automatic logic [ALPHA_W-1:0] distinct_alphabet();
      logic [ALPHA_W-1:0] alpha;
      logic [BYTE_W-1:0]  b;
      bit                 used [256];
      for (int i = 0; i < 16; i++) begin
         do b = BYTE_W'($urandom_range(0, 255));
         while (used[b] || b == sirf_pkg::SYM_PLUS || b == sirf_pkg::SYM_MINUS);
         used[b] = 1'b1;
         alpha[BYTE_W*i +: BYTE_W] = b;
      end
      return alpha;
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 9))
         5:       return $urandom_range(0, 300);
         6:       return -$signed($urandom_range(1, 300));
         7:       return $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
         8:       return $urandom >> $urandom_range(0, 31);
         9:       return -$signed($urandom >> $urandom_range(1, 31));
         default: return $urandom;
      endcase
   endfunction

   function automatic int unsigned pick_gap(input bit gappy);
      if (gappy && $urandom_range(0, 2) == 0)
         return $urandom_range(1, 18);
      return 0;
   endfunction

   // Builds a random alphabet: mostly valid, otherwise broken in one way.
   task random_alphabet();
      logic [ALPHA_W-1:0] alpha;
      logic [COUNT_W-1:0] count;
      alphabet_flaw_type  flaw;
      int unsigned        i;
      int unsigned        j;
      alpha = distinct_alphabet();
      case ($urandom_range(0, 3))
         0:       count = $urandom_range(0, 1) ? COUNT_W'(2) : COUNT_W'(16);
         default: count = COUNT_W'($urandom_range(2, 16));
      endcase
      // Symbols past the count are never checked, so they may hold anything.
      for (int k = 0; k < 16; k++)
         if (k >= count && $urandom_range(0, 1))
            alpha = put_symbol(alpha, k, BYTE_W'($urandom));
      if ($urandom_range(0, 4) == 0) begin
         flaw = alphabet_flaw_type'($urandom_range(0, 4));
         i = $urandom_range(0, count - 2);
         j = $urandom_range(i + 1, count - 1);
         case (flaw)
            FLAW_SHORT:  count = COUNT_W'($urandom_range(0, 1));
            FLAW_LONG:   count = COUNT_W'($urandom_range(17, 31));
            FLAW_PLUS:   alpha = put_symbol(alpha, j, sirf_pkg::SYM_PLUS);
            FLAW_MINUS:  alpha = put_symbol(alpha, i, sirf_pkg::SYM_MINUS);
            FLAW_REPEAT: alpha = put_symbol(alpha, j, alpha[BYTE_W*i +: BYTE_W]);
            default: ;
         endcase
      end
      load_alphabet(count, alpha);
   endtask

   initial begin
      logic [ALPHA_W-1:0] alpha;
      int unsigned        batch;
      bit                 gappy;

      text_check  = new();
      idle_cycles = 0;
      sent        = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_value   = '0;
      csr_valid   = 1'b0;
      csr_index   = sirf_pkg::CSR_SYMBOL_COUNT;
      csr_data    = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // After reset the count is zero, so the alphabet is refused.
      send_value(0, 0);
      send_value(-1, 2);

      load_alphabet(COUNT_W'(1), HEX_ALPHABET);
      send_value(5, 0);

      // Binary: the most negative value gives the longest text.
      load_alphabet(COUNT_W'(2), HEX_ALPHABET);
      send_value(VALUE_MIN, 0);
      send_value(VALUE_MAX, 0);
      send_value(0, 3);

      load_alphabet(COUNT_W'(16), HEX_ALPHABET);
      send_value(-1, 0);
      send_value(VALUE_MIN, 0);
      send_value(VALUE_MAX, 0);
      send_value(32'sh1234_5678, 0);

      load_alphabet(COUNT_W'(17), HEX_ALPHABET);
      send_value(7, 0);
      load_alphabet(COUNT_W'(31), HEX_ALPHABET);
      send_value(-7, 0);

      load_alphabet(COUNT_W'(10), put_symbol(HEX_ALPHABET, 3, sirf_pkg::SYM_PLUS));
      send_value(42, 0);
      load_alphabet(COUNT_W'(10), put_symbol(HEX_ALPHABET, 9, sirf_pkg::SYM_MINUS));
      send_value(123, 0);
      load_alphabet(COUNT_W'(10), put_symbol(HEX_ALPHABET, 7, "2"));
      send_value(-456, 0);

      // Faults beyond the count are outside the alphabet and do not matter.
      alpha = put_symbol(HEX_ALPHABET, 6, sirf_pkg::SYM_PLUS);
      alpha = put_symbol(alpha, 12, sirf_pkg::SYM_MINUS);
      alpha = put_symbol(alpha, 10, "0");
      load_alphabet(COUNT_W'(4), alpha);
      send_value(-1000, 0);

      // A zero byte is a legal symbol.
      load_alphabet(COUNT_W'(3), put_symbol(HEX_ALPHABET, 0, sirf_pkg::SYM_NUL));
      send_value(9, 0);
      send_value(0, 1);
      write_spare();
      send_value(255, 0);

      load_alphabet(COUNT_W'(8), HEX_ALPHABET);
      send_value(VALUE_MIN, 0);

      while (sent < TARGET_ITEMS) begin
         random_alphabet();
         if ($urandom_range(0, 4) == 0)
            write_spare();
         gappy = $urandom_range(0, 3) != 0 && sent < CALM_FROM;
         batch = $urandom_range(4, 12);
         repeat (batch)
            send_value(pick_value(), pick_gap(gappy && sent < CALM_FROM));
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (text_check.outstanding() != 0)
         text_check.report($sformatf("%0d bytes never arrived", text_check.outstanding()));
      if (text_check.errors == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
